// ===== design/assert_macros.svh =====
// assertion macros shared by the codec rtl
// expects a clock named clk and a synchronous reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/mcc_pkg.sv =====
// types, codes and code tables of the morse codec
// no dependencies
`timescale 1ns / 1ps

package mcc_pkg;

  localparam int MAX_CODE_LEN = 5;
  localparam int CODE_W       = 5;
  localparam logic [5:0] FIRST_LEAF = 6'd31;

  typedef enum logic [0:0] {
    OP_DECODE = 1'b0,
    OP_ENCODE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    SYM_DOT   = 2'd0,
    SYM_DASH  = 2'd1,
    SYM_OTHER = 2'd2,
    SYM_END   = 2'd3
  } sym_t;

  typedef enum logic [2:0] {
    KIND_DOT     = 3'd0,
    KIND_DASH    = 3'd1,
    KIND_SPACE   = 3'd2,
    KIND_SLASH   = 3'd3,
    KIND_CHAR    = 3'd4,
    KIND_INVALID = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    JOB_SINGLE,
    JOB_MARKS,
    JOB_SPACE
  } job_mode_t;

  // decode state held in the state memory
  typedef struct packed {
    logic [5:0] path;
    logic       ovf;
    logic       open;
  } dec_state_t;

  // one output sequence handed to the emitter
  typedef struct packed {
    job_mode_t         mode;
    kind_t             kind;
    logic [7:0]        ch;
    logic [2:0]        len;
    logic [CODE_W-1:0] marks;
  } job_t;

  // code of one character, first mark in the msb, dash is 1
  typedef struct packed {
    logic              found;
    logic [2:0]        len;
    logic [CODE_W-1:0] marks;
  } code_t;

  // letter at each heap-ordered tree node, zero where none
  function automatic logic [7:0] node_letter(input logic [5:0] idx);
    logic [7:0] c;
    c = 8'h00;
    unique case (idx)
      6'd1:  c = "E";
      6'd2:  c = "T";
      6'd3:  c = "I";
      6'd4:  c = "A";
      6'd5:  c = "N";
      6'd6:  c = "M";
      6'd7:  c = "S";
      6'd8:  c = "U";
      6'd9:  c = "R";
      6'd10: c = "W";
      6'd11: c = "D";
      6'd12: c = "K";
      6'd13: c = "G";
      6'd14: c = "O";
      6'd15: c = "H";
      6'd16: c = "V";
      6'd17: c = "F";
      6'd19: c = "L";
      6'd21: c = "P";
      6'd22: c = "J";
      6'd23: c = "B";
      6'd24: c = "X";
      6'd25: c = "C";
      6'd26: c = "Y";
      6'd27: c = "Z";
      6'd28: c = "Q";
      6'd31: c = "5";
      6'd32: c = "4";
      6'd34: c = "3";
      6'd38: c = "2";
      6'd46: c = "1";
      6'd47: c = "6";
      6'd55: c = "7";
      6'd59: c = "8";
      6'd61: c = "9";
      6'd62: c = "0";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // marks of an upper-case letter or digit
  function automatic code_t code_lookup(input logic [7:0] c);
    code_t r;
    r = '0;
    r.found = 1'b1;
    unique case (c)
      "A": begin r.len = 3'd2; r.marks = 5'b01000; end
      "B": begin r.len = 3'd4; r.marks = 5'b10000; end
      "C": begin r.len = 3'd4; r.marks = 5'b10100; end
      "D": begin r.len = 3'd3; r.marks = 5'b10000; end
      "E": begin r.len = 3'd1; r.marks = 5'b00000; end
      "F": begin r.len = 3'd4; r.marks = 5'b00100; end
      "G": begin r.len = 3'd3; r.marks = 5'b11000; end
      "H": begin r.len = 3'd4; r.marks = 5'b00000; end
      "I": begin r.len = 3'd2; r.marks = 5'b00000; end
      "J": begin r.len = 3'd4; r.marks = 5'b01110; end
      "K": begin r.len = 3'd3; r.marks = 5'b10100; end
      "L": begin r.len = 3'd4; r.marks = 5'b01000; end
      "M": begin r.len = 3'd2; r.marks = 5'b11000; end
      "N": begin r.len = 3'd2; r.marks = 5'b10000; end
      "O": begin r.len = 3'd3; r.marks = 5'b11100; end
      "P": begin r.len = 3'd4; r.marks = 5'b01100; end
      "Q": begin r.len = 3'd4; r.marks = 5'b11010; end
      "R": begin r.len = 3'd3; r.marks = 5'b01000; end
      "S": begin r.len = 3'd3; r.marks = 5'b00000; end
      "T": begin r.len = 3'd1; r.marks = 5'b10000; end
      "U": begin r.len = 3'd3; r.marks = 5'b00100; end
      "V": begin r.len = 3'd4; r.marks = 5'b00010; end
      "W": begin r.len = 3'd3; r.marks = 5'b01100; end
      "X": begin r.len = 3'd4; r.marks = 5'b10010; end
      "Y": begin r.len = 3'd4; r.marks = 5'b10110; end
      "Z": begin r.len = 3'd4; r.marks = 5'b11000; end
      "1": begin r.len = 3'd5; r.marks = 5'b01111; end
      "2": begin r.len = 3'd5; r.marks = 5'b00111; end
      "3": begin r.len = 3'd5; r.marks = 5'b00011; end
      "4": begin r.len = 3'd5; r.marks = 5'b00001; end
      "5": begin r.len = 3'd5; r.marks = 5'b00000; end
      "6": begin r.len = 3'd5; r.marks = 5'b10000; end
      "7": begin r.len = 3'd5; r.marks = 5'b11000; end
      "8": begin r.len = 3'd5; r.marks = 5'b11100; end
      "9": begin r.len = 3'd5; r.marks = 5'b11110; end
      "0": begin r.len = 3'd5; r.marks = 5'b11111; end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/mcc_ram.sv =====
// generic single-port-write, registered-read ram
// no dependencies
`timescale 1ns / 1ps

module mcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-cycle write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/mcc_emitter.sv =====
// output sequencer: turns one job into a run of result transactions
// depends on mcc_pkg
`timescale 1ns / 1ps

module mcc_emitter (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  mcc_pkg::job_t job_in,
  output logic          job_ready,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    out_kind,
  output logic [7:0]    out_char,
  output logic          last
);

  logic                       busy;
  mcc_pkg::job_t              job;
  logic [2:0]                 cnt;
  logic                       advance;
  mcc_pkg::kind_t             cur_kind;
  logic [7:0]                 cur_char;
  logic                       cur_last;

  assign advance   = busy && (!out_valid || !out_stall);
  assign job_ready = !busy || (advance && cur_last);

  // result at the current step of the job
  always_comb begin
    cur_kind = mcc_pkg::KIND_SPACE;
    cur_char = 8'h00;
    cur_last = 1'b0;
    unique case (job.mode)
      mcc_pkg::JOB_SINGLE: begin
        cur_kind = job.kind;
        cur_char = job.ch;
        cur_last = 1'b1;
      end
      mcc_pkg::JOB_MARKS: begin
        if (cnt < job.len) begin
          cur_kind = job.marks[mcc_pkg::CODE_W-1] ? mcc_pkg::KIND_DASH : mcc_pkg::KIND_DOT;
        end else begin
          cur_kind = mcc_pkg::KIND_SPACE;
          cur_last = 1'b1;
        end
      end
      mcc_pkg::JOB_SPACE: begin
        cur_kind = (cnt == 3'd1) ? mcc_pkg::KIND_SLASH : mcc_pkg::KIND_SPACE;
        cur_last = (cnt == 3'd2);
      end
      default: begin
        cur_kind = mcc_pkg::KIND_SPACE;
        cur_last = 1'b1;
      end
    endcase
  end

  // job register and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (job_valid && job_ready) begin
      busy <= 1'b1;
    end else if (advance && cur_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      job <= job_in;
      cnt <= 3'd0;
    end else if (advance) begin
      job.marks <= {job.marks[mcc_pkg::CODE_W-2:0], 1'b0};
      cnt       <= cnt + 3'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind <= cur_kind;
      out_char <= cur_char;
      last     <= cur_last;
    end
  end

endmodule

// ===== design/morse_code_codec.sv =====
// morse codec, decode by tree walk and encode by code table
// path: an item passes the stage 1 register, the emitter job register and the output register
// throughput: one result per cycle from the emitter while out_stall is low; a letter or
//   digit gives code length plus one results, up to six
// reset: clears pipeline and output valids; the state ram entry reads as the root
//   with both flags clear until the first decode transaction writes it
`timescale 1ns / 1ps
`include "assert_macros.svh"

module morse_code_codec (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       opcode,
  input  logic [1:0] symbol,
  input  logic [7:0] text_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_char,
  output logic       last
);

  localparam int STATE_W = $bits(mcc_pkg::dec_state_t);

  // tree depth of a heap-ordered node
  function automatic logic [3:0] node_depth(input logic [5:0] idx);
    logic [5:0] i;
    logic [3:0] d;
    i = idx;
    d = 4'd0;
    for (int k = 0; k < 6; k++) begin
      if (i != 6'd0) begin
        i = (i - 6'd1) >> 1;
        d = d + 4'd1;
      end
    end
    return d;
  endfunction

  logic                 in_accept;
  logic                 s1_valid;
  mcc_pkg::op_t         s1_opcode;
  mcc_pkg::sym_t        s1_symbol;
  logic [7:0]           s1_char;
  logic                 s1_fwd;
  mcc_pkg::dec_state_t  s1_fwd_state;
  logic                 s1_mem_ok;
  logic                 s1_move;
  logic                 state_valid;

  logic                 wr_en;
  mcc_pkg::dec_state_t  wr_state;
  logic [STATE_W-1:0]   rd_data;

  mcc_pkg::dec_state_t  cur;
  mcc_pkg::dec_state_t  state_next;
  logic                 has_job;
  mcc_pkg::job_t        job;
  mcc_pkg::code_t       code;
  logic [7:0]           letter;
  logic                 job_ready;

  assign in_accept = in_valid && !in_stall;
  assign s1_move   = s1_valid && (!has_job || job_ready);
  assign in_stall  = s1_valid && !s1_move;
  assign wr_en     = s1_move && (s1_opcode == mcc_pkg::OP_DECODE);
  assign wr_state  = state_next;

  // decode state memory, entry 0 holds the open token
  mcc_ram #(
    .WIDTH (STATE_W),
    .DEPTH (2)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (1'b0),
    .wr_data (wr_state),
    .rd_en   (in_accept),
    .rd_addr (1'b0),
    .rd_data (rd_data)
  );

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      state_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (wr_en) begin
        state_valid <= 1'b1;
      end
    end
  end

  // stage 1 payload and forwarding of a write that overlaps the read
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_opcode    <= mcc_pkg::op_t'(opcode);
      s1_symbol    <= mcc_pkg::sym_t'(symbol);
      s1_char      <= text_char;
      s1_fwd       <= wr_en;
      s1_fwd_state <= wr_state;
      s1_mem_ok    <= state_valid;
    end
  end

  // read-modify-write of the decode state and job build
  always_comb begin
    if (s1_fwd) begin
      cur = s1_fwd_state;
    end else if (s1_mem_ok) begin
      cur = mcc_pkg::dec_state_t'(rd_data);
    end else begin
      cur = '0;
    end
    state_next = cur;
    has_job    = 1'b0;
    job        = '0;
    letter     = mcc_pkg::node_letter(cur.path);
    code       = mcc_pkg::code_lookup(s1_char);
    unique case (s1_opcode)
      mcc_pkg::OP_DECODE: begin
        unique case (s1_symbol)
          mcc_pkg::SYM_DOT, mcc_pkg::SYM_DASH: begin
            state_next.open = 1'b1;
            if (!cur.ovf) begin
              if (cur.path >= mcc_pkg::FIRST_LEAF ||
                  node_depth(cur.path) >= 4'(mcc_pkg::MAX_CODE_LEN)) begin
                state_next.ovf = 1'b1;
              end else begin
                state_next.path = {cur.path[4:0], 1'b0} + 6'd1 + {5'd0, s1_symbol[0]};
              end
            end
          end
          mcc_pkg::SYM_OTHER: begin
            state_next.open = 1'b1;
          end
          mcc_pkg::SYM_END: begin
            if (cur.open) begin
              has_job  = 1'b1;
              job.mode = mcc_pkg::JOB_SINGLE;
              priority if (cur.ovf) begin
                job.kind = mcc_pkg::KIND_INVALID;
              end else if (cur.path == 6'd0) begin
                job.kind = mcc_pkg::KIND_SPACE;
              end else if (letter == 8'h00) begin
                job.kind = mcc_pkg::KIND_INVALID;
              end else begin
                job.kind = mcc_pkg::KIND_CHAR;
                job.ch   = letter;
              end
              state_next = '0;
            end
          end
          default: state_next = cur;
        endcase
      end
      mcc_pkg::OP_ENCODE: begin
        if (s1_char == " ") begin
          has_job  = 1'b1;
          job.mode = mcc_pkg::JOB_SPACE;
        end else if (code.found) begin
          has_job   = 1'b1;
          job.mode  = mcc_pkg::JOB_MARKS;
          job.len   = code.len;
          job.marks = code.marks;
        end
      end
      default: has_job = 1'b0;
    endcase
  end

  // result sequencer with output register
  mcc_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .job_valid (s1_valid && has_job),
    .job_in    (job),
    .job_ready (job_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_char  (out_char),
    .last      (last)
  );

  // checks on internal consistency
  `ASSERT_IMPLIES(a_stall_needs_item, in_stall, s1_valid, "input stalled with stage 1 empty")
  `ASSERT_IMPLIES(a_closed_is_root, wr_en && !wr_state.open,
    wr_state.path == 6'd0 && !wr_state.ovf, "closed token left off the root")
  `ASSERT_IMPLIES(a_char_only_decoded, out_valid && out_kind != mcc_pkg::KIND_CHAR,
    out_char == 8'h00, "character set on a non-character result")
  `ASSERT_ALWAYS(a_kind_range, !out_valid || out_kind <= mcc_pkg::KIND_INVALID,
    "result kind out of range")

endmodule
